// ===== design/cfwn_pkg.sv =====
`default_nettype none
package cfwn_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_NOISE,
        ST_SUM,
        ST_DONE
    } cfwn_state_t;

    typedef enum logic {
        REQ_AUDIO = 1'b0,
        REQ_COEF  = 1'b1
    } cfwn_req_t;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_GAIN = 2'd2;

    localparam int SAMPLE_W    = 16;
    localparam int TAP_COUNT_W = 7;
    localparam int GAIN_W      = 23;
    localparam int COEF_IDX_W  = 6;
    localparam int NOISE_PW    = 41;  // 17-bit noise term x 24-bit signed gain
    localparam int FRAC_SHIFT  = 20;
    localparam int FILT_SHIFT  = 5;

    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 7'd1;
    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -16'sd32767;

endpackage
`default_nettype wire

// ===== design/channel_fir_with_noise.sv =====
`default_nettype none
// Channel    | Direction | Handshake               | Payload
// item       | in        | item_valid / item_stall | req_type, sample_in, noise_in,
//            |           |                         | coef_index, coef_value
// result     | out       | result_valid / result_stall | channel_out
// cfg        | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Audio item: the single multiplier steps through the taps one per cycle (tap_count
// capped at MAX_TAPS), then the tap pipeline drains, then the noise multiply and the
// sum run; the result is registered at the final step, and no further item is taken
// until that step completes.
// Coefficient item: written on acceptance, with no busy state. rst_n clears control,
// pointers and valid bits; unwritten delay and coefficient entries read as zero. A
// held result only blocks the next audio item at its final step.
module channel_fir_with_noise #(
    parameter int MAX_TAPS = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  item_valid,
    output logic                                       item_stall,
    input  wire logic                                  req_type,
    input  wire logic signed [cfwn_pkg::SAMPLE_W-1:0]  sample_in,
    input  wire logic signed [cfwn_pkg::SAMPLE_W-1:0]  noise_in,
    input  wire logic [cfwn_pkg::COEF_IDX_W-1:0]       coef_index,
    input  wire logic signed [cfwn_pkg::SAMPLE_W-1:0]  coef_value,
    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output logic signed [cfwn_pkg::SAMPLE_W-1:0]       channel_out,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [cfwn_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [cfwn_pkg::GAIN_W-1:0]           cfg_data
);

    import cfwn_pkg::*;

    localparam int AW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TW   = $clog2(MAX_TAPS + 1);
    localparam int CXW  = (AW > COEF_IDX_W) ? AW : COEF_IDX_W;
    localparam int ACCW = 32 + AW;
    localparam int TOTW = (((ACCW + FILT_SHIFT) > NOISE_PW) ? (ACCW + FILT_SHIFT) : NOISE_PW) + 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
    localparam logic [TW-1:0] FULL      = TW'(MAX_TAPS);

    cfwn_state_t state_reg, state_next;

    logic [TAP_COUNT_W-1:0] tap_count_reg;
    logic                   noise_mode_reg;
    logic [GAIN_W-1:0]      noise_gain_reg;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [SAMPLE_W-1:0] noise_reg;
    logic signed [SAMPLE_W-1:0] last_noise_reg;

    logic [AW-1:0] wp_reg;
    logic [AW-1:0] rp_reg;
    logic [TW-1:0] fill_reg;
    logic [TW-1:0] j_reg;
    logic [MAX_TAPS-1:0] coef_vld_reg;

    logic rd_v_reg, dv_reg, cv_reg, prod_v_reg;
    logic signed [31:0]       prod_reg;
    logic signed [ACCW-1:0]   acc_reg;
    logic signed [NOISE_PW-1:0] nprod_reg;
    logic signed [TOTW-1:0]   total_reg;

    logic                       result_valid_reg, result_valid_next;
    logic signed [SAMPLE_W-1:0] result_reg, result_next;

    logic [TW-1:0] taps_eff;
    logic          accept, accept_audio, coef_we, issue, load_out;
    logic [CXW-1:0] cidx_x;
    logic [AW-1:0]  coef_waddr;
    logic [SAMPLE_W-1:0] dly_rdata, coef_rdata;
    logic signed [SAMPLE_W-1:0] mul_a, mul_b;
    logic signed [SAMPLE_W:0]   nterm;
    logic signed [TOTW-1:0]     biased, whole;

    assign taps_eff = (32'(tap_count_reg) > 32'(MAX_TAPS)) ? FULL : TW'(tap_count_reg);
    assign cidx_x     = CXW'(coef_index);
    assign coef_waddr = cidx_x[AW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && req_type == REQ_AUDIO)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (j_reg == taps_eff)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_v_reg && !prod_v_reg)
                begin
                    state_next = ST_NOISE;
                end
            end
            ST_NOISE: state_next = ST_SUM;
            ST_SUM:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        item_stall   = (state_reg != ST_IDLE);
        accept       = item_valid && (state_reg == ST_IDLE);
        accept_audio = accept && (req_type == REQ_AUDIO);
        coef_we      = accept && (req_type == REQ_COEF) && (32'(coef_index) < 32'(MAX_TAPS));
        issue        = (state_reg == ST_MAC) && (j_reg != taps_eff);
        load_out     = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);
    end

    assign cfg_ready = 1'b1;

    cfwn_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_delay (
        .clk   (clk),
        .we    (state_reg == ST_SUM),
        .waddr (wp_reg),
        .wdata (sample_reg),
        .raddr (rp_reg),
        .rdata (dly_rdata)
    );

    cfwn_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_coef (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_value),
        .raddr (j_reg[AW-1:0]),
        .rdata (coef_rdata)
    );

    assign mul_a = dv_reg ? $signed(dly_rdata) : '0;
    assign mul_b = cv_reg ? $signed(coef_rdata) : '0;

    assign nterm = noise_mode_reg
                 ? ($signed({last_noise_reg[SAMPLE_W-1], last_noise_reg})
                    - $signed({noise_reg[SAMPLE_W-1], noise_reg}))
                 : $signed({noise_reg[SAMPLE_W-1], noise_reg});

    // truncate toward zero, then saturate to OUT_MIN..OUT_MAX
    always_comb
    begin
        biased = total_reg + (total_reg[TOTW-1] ? TOTW'((1 << FRAC_SHIFT) - 1) : TOTW'(0));
        whole  = biased >>> FRAC_SHIFT;
        result_next = result_reg;
        if (load_out)
        begin
            priority if (whole > TOTW'(OUT_MAX))
                result_next = OUT_MAX;
            else if (whole < TOTW'(OUT_MIN))
                result_next = OUT_MIN;
            else
                result_next = whole[SAMPLE_W-1:0];
        end
        result_valid_next = load_out ? 1'b1 : (result_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            tap_count_reg    <= TAP_COUNT_RST;
            noise_mode_reg   <= 1'b0;
            noise_gain_reg   <= '0;
            last_noise_reg   <= '0;
            wp_reg           <= '0;
            rp_reg           <= '0;
            fill_reg         <= '0;
            j_reg            <= '0;
            coef_vld_reg     <= '0;
            rd_v_reg         <= 1'b0;
            prod_v_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            rd_v_reg         <= issue;
            prod_v_reg       <= rd_v_reg;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_TAP_COUNT:  tap_count_reg  <= cfg_data[TAP_COUNT_W-1:0];
                    CFG_NOISE_MODE: noise_mode_reg <= cfg_data[0];
                    CFG_NOISE_GAIN: noise_gain_reg <= cfg_data;
                    default:        ;
                endcase
            end

            if (coef_we)
            begin
                coef_vld_reg[coef_waddr] <= 1'b1;
            end

            if (accept_audio)
            begin
                j_reg  <= '0;
                rp_reg <= wp_reg;
            end
            else if (issue)
            begin
                j_reg  <= j_reg + TW'(1);
                rp_reg <= (rp_reg == LAST_ADDR) ? '0 : rp_reg + AW'(1);
            end

            if (state_reg == ST_SUM)
            begin
                wp_reg         <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + AW'(1);
                last_noise_reg <= noise_reg;
                if (fill_reg != FULL)
                begin
                    fill_reg <= fill_reg + TW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_audio)
        begin
            sample_reg <= sample_in;
            noise_reg  <= noise_in;
            acc_reg    <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + ACCW'(prod_reg);
        end
        dv_reg    <= issue && (TW'(rp_reg) < fill_reg);
        cv_reg    <= issue && coef_vld_reg[j_reg[AW-1:0]];
        prod_reg  <= mul_a * mul_b;
        if (state_reg == ST_NOISE)
        begin
            nprod_reg <= nterm * $signed({1'b0, noise_gain_reg});
        end
        if (state_reg == ST_SUM)
        begin
            total_reg <= (TOTW'(acc_reg) <<< FILT_SHIFT) + TOTW'(nprod_reg);
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign channel_out  = result_reg;

`ifndef SYNTHESIS
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NOISE |-> !rd_v_reg && !prod_v_reg)
        else $error("tap pipeline not empty at noise step");

    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAC |-> j_reg <= taps_eff)
        else $error("tap counter beyond tap count");

    a_fill_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != FULL |-> TW'(wp_reg) == fill_reg)
        else $error("write pointer and fill count disagree");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside final step");

    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> result_reg != -16'sd32768)
        else $error("result outside saturation range");
`endif

endmodule
`default_nettype wire

// ===== design/cfwn_ram.sv =====
`default_nettype none
module cfwn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
